// ===== hw/rtl/crra_pkg.sv =====
// Package for the contiguous ring region allocator.
// Holds op and status codes, state and result structs, and the size clamp.
// No dependencies.
`timescale 1ns / 1ps

package crra_pkg;

    localparam int SIZE_W = 17;
    localparam int OFS_W  = 16;
    localparam logic [SIZE_W-1:0] MAX_BYTES = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0] MIN_BYTES = SIZE_W'(2);

    typedef enum logic [1:0] {
        OP_RESERVE_WRITE = 2'd0,
        OP_COMMIT_WRITE  = 2'd1,
        OP_RESERVE_READ  = 2'd2,
        OP_COMMIT_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_PAST_WRAP = 2'd2,
        ST_BOUNDARY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [SIZE_W-1:0] rd_off;
        logic [SIZE_W-1:0] wr_off;
        logic [SIZE_W-1:0] pend_rd;
        logic [SIZE_W-1:0] pend_wr;
        logic [SIZE_W-1:0] wrap;
    } t_state;

    typedef struct packed {
        logic             granted;
        logic [OFS_W-1:0] offset;
        t_status          status;
    } t_result;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r > MAX_BYTES) r = MAX_BYTES;
        if (r < MIN_BYTES) r = MIN_BYTES;
        return r;
    endfunction

endpackage

// ===== hw/rtl/crra_if.sv =====
// Handshake interfaces for the allocator's op and result channels.
// Depends on crra_pkg.
`timescale 1ns / 1ps

interface crra_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [crra_pkg::SIZE_W-1:0] length;

    modport source (output valid, output op, output length, input ready);
    modport sink   (input valid, input op, input length, output ready);
endinterface

interface crra_out_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [crra_pkg::OFS_W-1:0] offset;
    logic [1:0]                 status;

    modport source (output valid, output granted, output offset, output status, input ready);
    modport sink   (input valid, input granted, input offset, input status, output ready);
endinterface

// ===== hw/rtl/crra_step.sv =====
// Next-state and result logic for one allocator op.
// Depends on crra_pkg.
`timescale 1ns / 1ps

module crra_step (
    input  crra_pkg::t_state               i_state,
    input  logic [crra_pkg::SIZE_W-1:0]    i_size,
    input  crra_pkg::t_op                  i_op,
    input  logic [crra_pkg::SIZE_W-1:0]    i_length,
    output crra_pkg::t_state               o_state,
    output crra_pkg::t_result              o_result
);
    import crra_pkg::*;

    logic [SIZE_W:0]   w_sum;
    logic [SIZE_W:0]   r_sum;
    logic [SIZE_W-1:0] rd0;
    logic [SIZE_W-1:0] grant_ofs;

    assign w_sum = {1'b0, i_state.wr_off} + {1'b0, i_state.pend_wr};
    assign r_sum = {1'b0, i_state.rd_off} + {1'b0, i_state.pend_rd};
    assign rd0   = (i_state.rd_off == i_state.wrap) ? '0 : i_state.rd_off;

    always_comb begin
        o_state          = i_state;
        o_result.granted = 1'b0;
        o_result.status  = ST_OK;
        grant_ofs        = '0;
        case (i_op)
            OP_RESERVE_WRITE: begin
                if (i_state.rd_off <= i_state.wr_off) begin
                    if (i_size >= i_state.wr_off && i_size - i_state.wr_off >= i_length) begin
                        o_state.pend_wr  = i_length;
                        o_result.granted = 1'b1;
                        grant_ofs        = i_state.wr_off;
                    end else if (i_state.rd_off > i_length) begin
                        o_state.wrap     = i_state.wr_off;
                        o_state.wr_off   = '0;
                        o_state.pend_wr  = i_length;
                        o_result.granted = 1'b1;
                    end else begin
                        o_result.status = ST_NO_ROOM;
                    end
                end else begin
                    if (i_state.rd_off - i_state.wr_off - SIZE_W'(1) >= i_length) begin
                        o_state.pend_wr  = i_length;
                        o_result.granted = 1'b1;
                        grant_ofs        = i_state.wr_off;
                    end else begin
                        o_result.status = ST_NO_ROOM;
                    end
                end
            end
            OP_COMMIT_WRITE: begin
                o_state.pend_wr = '0;
                if (w_sum == {1'b0, i_size}) begin
                    o_state.wr_off = '0;
                end else if (w_sum > {1'b0, i_size}) begin
                    o_state.wr_off  = '0;
                    o_result.status = ST_BOUNDARY;
                end else begin
                    o_state.wr_off = w_sum[SIZE_W-1:0];
                end
            end
            OP_RESERVE_READ: begin
                o_state.rd_off = rd0;
                if (rd0 <= i_state.wr_off) begin
                    if (i_state.wr_off - rd0 >= i_length) begin
                        o_state.pend_rd  = i_length;
                        o_result.granted = 1'b1;
                        grant_ofs        = rd0;
                    end else begin
                        o_result.status = ST_NO_ROOM;
                    end
                end else begin
                    if (i_state.wrap >= rd0 && i_state.wrap - rd0 >= i_length) begin
                        o_state.pend_rd  = i_length;
                        o_result.granted = 1'b1;
                        grant_ofs        = rd0;
                    end else begin
                        o_result.status = ST_PAST_WRAP;
                    end
                end
            end
            OP_COMMIT_READ: begin
                o_state.pend_rd = '0;
                if (r_sum == {1'b0, i_state.wrap}) begin
                    o_state.rd_off = '0;
                end else if (r_sum > {1'b0, i_state.wrap}) begin
                    o_state.rd_off  = '0;
                    o_result.status = ST_BOUNDARY;
                end else begin
                    o_state.rd_off = r_sum[SIZE_W-1:0];
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.offset = grant_ofs[OFS_W-1:0];
    end

endmodule

// ===== hw/rtl/contiguous_ring_region_allocator_core.sv =====
// Top level of the contiguous ring region allocator: input register,
// bookkeeping state, result register. Depends on crra_pkg, crra_if, crra_step.
//
//   channel   dir   beat fields               handshake
//   i_in      in    op, length                valid/ready
//   o_out     out   granted, offset, status   valid/ready
//   cfg       in    i_cfg_data (buffer_size)  i_cfg_we, no ready
//
// One op per cycle sustained while o_out is not stalled; each op passes through the
// input register, then crra_step, then the result register on its way to the result beat.
// State updates when an op moves from the input register to the result register.
// Reset (synchronous) empties both registers, clears offsets and sets size 65536.
// A stalled result holds the result register; the input register still fills while it is empty.
`timescale 1ns / 1ps

module contiguous_ring_region_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crra_pkg::SIZE_W-1:0] i_cfg_data,
    crra_in_if.sink                     i_in,
    crra_out_if.source                  o_out
);
    import crra_pkg::*;

    logic              r_in_valid;
    t_op               r_in_op;
    logic [SIZE_W-1:0] r_in_length;
    logic              r_out_valid;
    t_result           r_out;
    t_state            r_state;
    logic [SIZE_W-1:0] r_size;

    t_state            n_state;
    t_result           n_out;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    crra_step u_step (
        .i_state  (r_state),
        .i_size   (r_size),
        .i_op     (r_in_op),
        .i_length (r_in_length),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_size      <= MAX_BYTES;
            r_state     <= '{rd_off: '0, wr_off: '0, pend_rd: '0, pend_wr: '0,
                             wrap: MAX_BYTES};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_size  <= clamp_size(i_cfg_data);
                r_state <= '{rd_off: '0, wr_off: '0, pend_rd: '0, pend_wr: '0,
                             wrap: clamp_size(i_cfg_data)};
            end else if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_op     <= t_op'(i_in.op);
            r_in_length <= i_in.length;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.granted = r_out.granted;
    assign o_out.offset  = r_out.offset;
    assign o_out.status  = r_out.status;

`ifndef SYNTHESIS
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.granted) |-> (r_out.status == ST_OK))
        else $error("granted result with nonzero status");

    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.granted) |-> (r_out.offset == '0))
        else $error("refused result with nonzero offset");

    a_commit_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op == OP_COMMIT_WRITE || r_in_op == OP_COMMIT_READ))
        |=> !r_out.granted)
        else $error("commit produced a grant");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state.rd_off == '0 && r_state.wr_off == '0 &&
                      r_state.pend_rd == '0 && r_state.pend_wr == '0 &&
                      r_state.wrap == r_size))
        else $error("config write did not clear bookkeeping");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("empty input register not ready");
`endif

endmodule

// ===== tb/tb_contiguous_ring_region_allocator_core.sv =====
// Testbench for contiguous_ring_region_allocator_core: drives reserve/commit ops,
// predicts each grant/offset/status beat and checks it against the result channel.
// Depends on crra_pkg, crra_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_contiguous_ring_region_allocator_core;
    import crra_pkg::*;

    localparam int HOLD_AT   = 200;
    localparam int HOLD_LEN  = 300;
    localparam int STALL_MAX = 2000;

    typedef struct packed {
        t_op               op;
        logic [SIZE_W-1:0] len;
    } t_op_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    crra_in_if  in_if ();
    crra_out_if out_if ();

    contiguous_ring_region_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_op_beat ops_q[$];
    t_result  answers_q[$];
    int       err_cnt = 0;
    int       tx_idle_pct;
    int       rx_idle_pct;
    int       rx_beats = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       quiet_cycles = 0;

    // Allocator bookkeeping as the predictor sees it
    logic [SIZE_W-1:0] ring_size;
    logic [SIZE_W-1:0] rd_ofs;
    logic [SIZE_W-1:0] wr_ofs;
    logic [SIZE_W-1:0] rd_pend;
    logic [SIZE_W-1:0] wr_pend;
    logic [SIZE_W-1:0] wrap_at;

    function automatic void set_ring_size(input logic [SIZE_W-1:0] v);
        if (v > MAX_BYTES)
            ring_size = MAX_BYTES;
        else if (v < MIN_BYTES)
            ring_size = MIN_BYTES;
        else
            ring_size = v;
        rd_ofs  = '0;
        wr_ofs  = '0;
        rd_pend = '0;
        wr_pend = '0;
        wrap_at = ring_size;
    endfunction

    function automatic t_result ring_step(input t_op op, input logic [SIZE_W-1:0] n);
        t_result         res;
        logic [SIZE_W:0] sum;
        res.granted = 1'b0;
        res.offset  = '0;
        res.status  = ST_OK;
        case (op)
            OP_RESERVE_WRITE: begin
                if (rd_ofs <= wr_ofs) begin
                    if (ring_size >= wr_ofs && ring_size - wr_ofs >= n) begin
                        wr_pend     = n;
                        res.granted = 1'b1;
                        res.offset  = wr_ofs[OFS_W-1:0];
                    end else if (rd_ofs > n) begin
                        wrap_at     = wr_ofs;
                        wr_ofs      = '0;
                        wr_pend     = n;
                        res.granted = 1'b1;
                    end else begin
                        res.status = ST_NO_ROOM;
                    end
                end else if (rd_ofs - wr_ofs - SIZE_W'(1) >= n) begin
                    wr_pend     = n;
                    res.granted = 1'b1;
                    res.offset  = wr_ofs[OFS_W-1:0];
                end else begin
                    res.status = ST_NO_ROOM;
                end
            end
            OP_COMMIT_WRITE: begin
                sum = {1'b0, wr_ofs} + {1'b0, wr_pend};
                if (sum == {1'b0, ring_size}) begin
                    sum = '0;
                end else if (sum > {1'b0, ring_size}) begin
                    res.status = ST_BOUNDARY;
                    sum = '0;
                end
                wr_ofs  = sum[SIZE_W-1:0];
                wr_pend = '0;
            end
            OP_RESERVE_READ: begin
                if (rd_ofs == wrap_at)
                    rd_ofs = '0;
                if (rd_ofs <= wr_ofs) begin
                    if (wr_ofs - rd_ofs >= n) begin
                        rd_pend     = n;
                        res.granted = 1'b1;
                        res.offset  = rd_ofs[OFS_W-1:0];
                    end else begin
                        res.status = ST_NO_ROOM;
                    end
                end else if (wrap_at >= rd_ofs && wrap_at - rd_ofs >= n) begin
                    rd_pend     = n;
                    res.granted = 1'b1;
                    res.offset  = rd_ofs[OFS_W-1:0];
                end else begin
                    res.status = ST_PAST_WRAP;
                end
            end
            default: begin
                sum = {1'b0, rd_ofs} + {1'b0, rd_pend};
                if (sum == {1'b0, wrap_at}) begin
                    sum = '0;
                end else if (sum > {1'b0, wrap_at}) begin
                    res.status = ST_BOUNDARY;
                    sum = '0;
                end
                rd_ofs  = sum[SIZE_W-1:0];
                rd_pend = '0;
            end
        endcase
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_length(input int unsigned sz);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return SIZE_W'($urandom_range(sz / 3 + 1, 0));
        if (r < 85)
            return SIZE_W'($urandom_range(sz, 0));
        if (r < 95)
            return SIZE_W'($urandom_range(sz + 2, sz));
        return SIZE_W'($urandom_range((1 << SIZE_W) - 1, 0));
    endfunction

    task automatic push_op(input t_op op, input logic [SIZE_W-1:0] n);
        t_op_beat b;
        b.op  = op;
        b.len = n;
        ops_q.push_back(b);
    endtask

    // Mostly reserve/commit pairs with random lengths, some stray ops
    task automatic push_random_ops(input int unsigned sz);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            push_op(OP_RESERVE_WRITE, pick_length(sz));
            push_op(OP_COMMIT_WRITE, SIZE_W'($urandom));
        end else if (r < 80) begin
            push_op(OP_RESERVE_READ, pick_length(sz));
            push_op(OP_COMMIT_READ, SIZE_W'($urandom));
        end else begin
            push_op(t_op'($urandom_range(3)), pick_length(sz));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (ops_q.size() != 0 || in_if.valid || answers_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ring_size(input logic [SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        set_ring_size(v);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : op_driver
        t_op_beat nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                answers_q.push_back(ring_step(t_op'(in_if.op), in_if.length));
            if (!in_if.valid || in_if.ready) begin
                if (ops_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = ops_q.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.op     <= nxt.op;
                    in_if.length <= nxt.len;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                rx_beats = rx_beats + 1;
                if (answers_q.size() == 0) begin
                    $error("unexpected result beat: granted %0d offset %0d status %0d",
                           out_if.granted, out_if.offset, out_if.status);
                    err_cnt++;
                end else begin
                    want = answers_q.pop_front();
                    if (out_if.granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, out_if.granted);
                        err_cnt++;
                    end
                    if (out_if.offset !== want.offset) begin
                        $error("offset: expected %0d, got %0d", want.offset, out_if.offset);
                        err_cnt++;
                    end
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_if.status);
                        err_cnt++;
                    end
                end
            end
            // hold off once for a long stretch so the input side backs up
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (rx_beats >= HOLD_AT && !hold_done) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_LEN;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [SIZE_W-1:0] phase_size [6];
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.op     = OP_RESERVE_WRITE;
        in_if.length = '0;
        out_if.ready = 1'b0;
        tx_idle_pct  = 15;
        rx_idle_pct  = 84;
        phase_size   = '{SIZE_W'(0), SIZE_W'(16), SIZE_W'(131071),
                         SIZE_W'(61), SIZE_W'(65536), SIZE_W'(300)};
        set_ring_size(MAX_BYTES);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-size ring: zero length, oversize, top offset, commit with nothing reserved
        push_op(OP_RESERVE_READ, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(1));
        push_op(OP_RESERVE_WRITE, SIZE_W'(131071));
        push_op(OP_RESERVE_WRITE, SIZE_W'(65535));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(100));
        push_op(OP_COMMIT_READ, SIZE_W'(131071));
        push_op(OP_RESERVE_WRITE, SIZE_W'(1));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        push_op(OP_RESERVE_WRITE, SIZE_W'(100));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        wait_drained();

        // small ring: wrap of the writer, read past wrap, commit past wrap
        write_ring_size(SIZE_W'(16));
        push_op(OP_RESERVE_WRITE, SIZE_W'(12));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(8));
        push_op(OP_COMMIT_READ, SIZE_W'(0));
        push_op(OP_RESERVE_WRITE, SIZE_W'(5));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(5));
        push_op(OP_RESERVE_READ, SIZE_W'(4));
        push_op(OP_COMMIT_READ, SIZE_W'(0));
        push_op(OP_RESERVE_WRITE, SIZE_W'(9));
        push_op(OP_COMMIT_WRITE, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(10));
        push_op(OP_COMMIT_READ, SIZE_W'(0));
        push_op(OP_RESERVE_READ, SIZE_W'(4));
        push_op(OP_COMMIT_READ, SIZE_W'(0));

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 2) begin
                tx_idle_pct = 84;
                rx_idle_pct = 15;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_ring_size(phase_size[ph]);
            repeat (90) push_random_ops(32'(ring_size));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && answers_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
